### rtl/core/mpq_pkg.sv
// Shared types and codes for the min priority queue.
// Holds the key and occupancy types, operation and status codes, the per-cell
// command and the bus that links neighbor cells. No dependencies.
`default_nettype none

package mpq_pkg;

  localparam int KEY_W = 32;
  localparam int OCC_W = 7;

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [OCC_W-1:0]        occ_t;
  typedef logic [1:0]              action_t;
  typedef logic [1:0]              status_t;

  localparam action_t ACT_INSERT  = 2'd0;
  localparam action_t ACT_EXTRACT = 2'd1;
  localparam action_t ACT_DELETE  = 2'd2;

  localparam status_t STS_OK       = 2'd0;
  localparam status_t STS_EMPTY    = 2'd1;
  localparam status_t STS_FULL     = 2'd2;
  localparam status_t STS_NOTFOUND = 2'd3;

  // Command broadcast to every cell in the apply cycle
  typedef enum logic [1:0] {
    CMD_HOLD = 2'd0,
    CMD_INS  = 2'd1,
    CMD_SHL  = 2'd2,
    CMD_DEL  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic cap;   // capture compare flags against the probe key
    cmd_t cmd;
  } cell_ctl_t;

  // What a cell shows its neighbors
  typedef struct packed {
    logic vld;
    logic gt;    // empty, or key above the probe
    logic ge;    // holds a key at or above the probe
    key_t key;
  } cell_bus_t;

endpackage

`default_nettype wire

### rtl/core/mpq_cell.sv
// One cell of the sorted queue chain: a key, its valid bit and compare flags.
// Depends on mpq_pkg for the control and neighbor bus types.
`default_nettype none

module mpq_cell (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire mpq_pkg::cell_ctl_t ctl_i,
  input  wire mpq_pkg::key_t     probe_key_i,
  input  wire mpq_pkg::key_t     ins_key_i,
  input  wire mpq_pkg::cell_bus_t left_i,
  input  wire mpq_pkg::cell_bus_t right_i,
  output mpq_pkg::cell_bus_t     self_o,
  output logic                   eq_o
);

  logic          vld_r;
  logic          vld_nxt;
  mpq_pkg::key_t key_r;
  mpq_pkg::key_t key_nxt;
  logic          gt_r;
  logic          ge_r;
  logic          eq_r;

  always_comb begin
    vld_nxt = vld_r;
    key_nxt = key_r;
    case (ctl_i.cmd)
      mpq_pkg::CMD_INS: begin
        // ripple right of the insertion point, take the new key at it
        if (left_i.gt) begin
          vld_nxt = left_i.vld;
          key_nxt = left_i.key;
        end else if (gt_r) begin
          vld_nxt = 1'b1;
          key_nxt = ins_key_i;
        end
      end
      mpq_pkg::CMD_SHL: begin
        vld_nxt = right_i.vld;
        key_nxt = right_i.key;
      end
      mpq_pkg::CMD_DEL: begin
        if (ge_r) begin
          vld_nxt = right_i.vld;
          key_nxt = right_i.key;
        end
      end
      default: begin
        vld_nxt = vld_r;
        key_nxt = key_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    if (ctl_i.cap) begin
      gt_r <= !vld_r || (key_r > probe_key_i);
      ge_r <= vld_r && (key_r >= probe_key_i);
      eq_r <= vld_r && (key_r == probe_key_i);
    end
  end

  assign self_o.vld = vld_r;
  assign self_o.gt  = gt_r;
  assign self_o.ge  = ge_r;
  assign self_o.key = key_r;
  assign eq_o       = eq_r;

endmodule

`default_nettype wire

### rtl/core/min_priority_queue_top.sv
// Min priority queue of signed 32-bit keys kept sorted in a chain of cells.
// Each word is handled in order: the cells capture their compare flags when it is
// accepted, then the apply state broadcasts the command across the cell chain and
// registers the result word, waiting while the previous result word is held in the
// output register by out_ready. No new word is taken until the current one is applied.
// Reset: synchronous, active low; clears all cell valid bits and the count,
// no clearing pass is needed, so the queue takes words right after reset.
`default_nettype none

module min_priority_queue_top #(
  parameter int CAPACITY = 64
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire mpq_pkg::action_t in_action,
  input  wire mpq_pkg::key_t   in_key,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output mpq_pkg::key_t        out_min_key,
  output mpq_pkg::status_t     out_status,
  output mpq_pkg::occ_t        out_occupancy
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_APPLY = 1'b1
  } state_t;

  state_t             state_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [CNT_W-1:0]   cnt_nxt;
  mpq_pkg::action_t   op_action_r;
  mpq_pkg::key_t      op_key_r;

  logic               out_valid_r;
  mpq_pkg::key_t      out_min_key_r;
  mpq_pkg::status_t   out_status_r;
  mpq_pkg::occ_t      out_occupancy_r;

  mpq_pkg::cell_bus_t bus   [CAPACITY];
  logic [CAPACITY-1:0] eq_v;
  mpq_pkg::cell_ctl_t ctl;

  logic               accept;
  logic               apply_en;
  logic               full;
  logic               empty;
  logic               found;
  mpq_pkg::cmd_t      cmd;
  mpq_pkg::key_t      res_key;
  mpq_pkg::status_t   res_status;

  // Accept only between operations; the cell flags are captured on accept
  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // Apply once the output register is free or being drained this cycle
  assign apply_en = (state_r == ST_APPLY) && (!out_valid_r || out_ready);

  assign full  = (cnt_r == CNT_W'(CAPACITY));
  assign empty = (cnt_r == '0);
  // Keys are sorted, so any equal cell means the key is present
  assign found = |eq_v;

  always_comb begin
    cmd        = mpq_pkg::CMD_HOLD;
    cnt_nxt    = cnt_r;
    res_key    = '0;
    res_status = mpq_pkg::STS_OK;
    case (op_action_r)
      mpq_pkg::ACT_INSERT: begin
        if (full) begin
          res_status = mpq_pkg::STS_FULL;
        end else begin
          cmd     = mpq_pkg::CMD_INS;
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      mpq_pkg::ACT_EXTRACT: begin
        if (empty) begin
          res_status = mpq_pkg::STS_EMPTY;
        end else begin
          // head cell holds the minimum; shift the whole chain toward it
          cmd     = mpq_pkg::CMD_SHL;
          cnt_nxt = cnt_r - CNT_W'(1);
          res_key = bus[0].key;
        end
      end
      mpq_pkg::ACT_DELETE: begin
        if (found) begin
          // close the gap at the first cell at or above the key
          cmd     = mpq_pkg::CMD_DEL;
          cnt_nxt = cnt_r - CNT_W'(1);
          res_key = op_key_r;
        end else begin
          res_status = mpq_pkg::STS_NOTFOUND;
        end
      end
      default: begin
        cmd = mpq_pkg::CMD_HOLD;
      end
    endcase
  end

  assign ctl.cap = accept;
  assign ctl.cmd = apply_en ? cmd : mpq_pkg::CMD_HOLD;

  // Cell chain: cell 0 is the head (smallest key)
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    mpq_pkg::cell_bus_t left_bus;
    mpq_pkg::cell_bus_t right_bus;

    if (i == 0) begin : g_head
      assign left_bus = '0;
    end else begin : g_left
      assign left_bus = bus[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_bus = '0;
    end else begin : g_right
      assign right_bus = bus[i+1];
    end

    mpq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl_i       (ctl),
      .probe_key_i (in_key),
      .ins_key_i   (op_key_r),
      .left_i      (left_bus),
      .right_i     (right_bus),
      .self_o      (bus[i]),
      .eq_o        (eq_v[i])
    );
  end

  // State, count and result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            state_r     <= ST_APPLY;
            op_action_r <= in_action;
            op_key_r    <= in_key;
          end
          if (out_ready) begin
            out_valid_r <= 1'b0;
          end
        end
        ST_APPLY: begin
          if (apply_en) begin
            state_r         <= ST_IDLE;
            cnt_r           <= cnt_nxt;
            out_valid_r     <= 1'b1;
            out_min_key_r   <= res_key;
            out_status_r    <= res_status;
            out_occupancy_r <= mpq_pkg::occ_t'(cnt_nxt);
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_min_key   = out_min_key_r;
  assign out_status    = out_status_r;
  assign out_occupancy = out_occupancy_r;

  // Count never exceeds the number of cells
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("key count above capacity");

  // Head cell is occupied exactly when the count is nonzero
  a_head_vld: assert property (@(posedge clk) disable iff (!rst_n)
    bus[0].vld == (cnt_r != '0))
    else $error("head cell valid disagrees with count");

  // If the second cell is occupied, the head cell is too and holds a key no larger
  a_head_order: assert property (@(posedge clk) disable iff (!rst_n)
    bus[1].vld |-> (bus[0].vld && (bus[0].key <= bus[1].key)))
    else $error("head cells out of order");

  // A new result word only follows an apply cycle
  a_out_after_apply: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_APPLY))
    else $error("result word without apply");

  // An empty report leaves the queue empty
  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == mpq_pkg::STS_EMPTY)) |-> (out_occupancy_r == '0))
    else $error("empty status with nonzero occupancy");

endmodule

`default_nettype wire
